### sv/gbte_pkg.sv
// gap buffer editor: shared types and constants
`default_nettype none
package gbte_pkg;

  typedef enum logic [2:0] {
    K_INSERT = 3'd0,
    K_BACKSPACE = 3'd1,
    K_LEFT = 3'd2,
    K_RIGHT = 3'd3,
    K_UP = 3'd4,
    K_DOWN = 3'd5,
    K_CLEAR = 3'd6,
    K_READ = 3'd7
  } kind_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_INSERT,
    CMD_BACKSPACE,
    CMD_SEL_PRE,
    CMD_SEL_POST,
    CMD_DROP_SEL,
    CMD_RD_PREV,
    CMD_RD_FIN,
    CMD_MV_LEFT,
    CMD_MV_RIGHT,
    CMD_MV_RIGHT_CNT,
    CMD_LOC_CLR,
    CMD_LOC_RD,
    CMD_LOC_ACC,
    CMD_TGT_SAVE,
    CMD_READ_ISSUE,
    CMD_READ_CAPT,
    CMD_OUT_LOAD
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_LEFT,
    S_LEFT_WR,
    S_RIGHT,
    S_RIGHT_WR,
    S_UP,
    S_UP_CHK,
    S_UP_LINE,
    S_UP_LINE_CHK,
    S_DOWN,
    S_DOWN_CHK,
    S_WALK,
    S_WALK_CHK,
    S_SEL_POST,
    S_LOC_START,
    S_LOC_CHK,
    S_LOC_ACC,
    S_TGT,
    S_FINISH
  } state_e;

  typedef struct packed {
    kind_e kind;
    logic  bs_char;
    logic  gb_zero;
    logic  at_end;
    logic  rd_lf;
    logic  loc_done;
    logic  walk_done;
    logic  out_busy;
  } dp_sts_t;

  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_DEL = 8'd127;

endpackage
`default_nettype wire

### sv/gbte_dpath.sv
// gap buffer editor: text memory, pointers, scan counters and result register
`default_nettype none
module gbte_dpath #(
  parameter int unsigned CAPACITY = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gbte_pkg::cmd_e cmd_i,
  input  wire logic [2:0]    kind_i,
  input  wire logic          extend_i,
  input  wire logic [7:0]    char_code_i,
  input  wire logic [11:0]   position_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output logic               status_o,
  output logic [12:0]        cursor_index_o,
  output logic [12:0]        cursor_row_o,
  output logic [15:0]        cursor_col_o,
  output logic [12:0]        text_length_o,
  output logic               sel_active_o,
  output logic [12:0]        sel_anchor_o,
  output logic [12:0]        sel_end_o,
  output logic [7:0]         char_out_o,
  output gbte_pkg::dp_sts_t  sts_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = (AW + 4 > 17) ? AW + 4 : 17;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_q;
  logic [PW-1:0] gb_q, gf_q, anchor_q, tail_q, idx_q, row_q;
  logic          sel_on_q, status_q, hit_q, out_valid_q;
  logic [CW-1:0] col_q, tgt_q, n_q;
  logic [7:0]    char_q;
  logic [2:0]    kind_q;
  logic          ext_q;
  logic [7:0]    ch_q;
  logic [11:0]   pos_q;

  logic          rd_en, wr_en, full, hit;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, ins_byte;
  logic [PW-1:0] len;
  logic [31:0]   pos_w, phys_w;
  logic [CW-1:0] col_next;

  assign full     = (gb_q == gf_q);
  assign len      = CAP_P - (gf_q - gb_q);
  assign pos_w    = 32'(pos_q);
  assign phys_w   = (pos_w < 32'(gb_q)) ? pos_w : pos_w + 32'(gf_q - gb_q);
  assign hit      = (pos_w < 32'(len)) && (phys_w < 32'(CAPACITY));
  assign ins_byte = (ch_q == gbte_pkg::CH_CR) ? gbte_pkg::CH_LF : ch_q;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd_i)
      gbte_pkg::CMD_RD_PREV:    rd_addr = AW'(gb_q - PW'(1));
      gbte_pkg::CMD_RD_FIN:     rd_addr = AW'(gf_q);
      gbte_pkg::CMD_LOC_RD:     rd_addr = AW'(idx_q);
      gbte_pkg::CMD_READ_ISSUE: rd_addr = phys_w[AW-1:0];
      default:                  rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(gb_q);
    wr_data = rd_q;
    case (cmd_i)
      gbte_pkg::CMD_INSERT: begin
        wr_en   = !full;
        wr_data = ins_byte;
      end
      gbte_pkg::CMD_MV_LEFT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(gf_q - PW'(1));
      end
      gbte_pkg::CMD_MV_RIGHT, gbte_pkg::CMD_MV_RIGHT_CNT: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == gbte_pkg::CMD_LATCH) begin
      kind_q <= kind_i;
      ext_q  <= extend_i;
      ch_q   <= char_code_i;
      pos_q  <= position_i;
    end
  end

  always_comb begin
    if (rd_q == gbte_pkg::CH_LF) begin
      col_next = '0;
    end else if (rd_q == gbte_pkg::CH_TAB) begin
      col_next = {col_q[CW-1:3] + (CW-3)'(1), 3'b000};
    end else begin
      col_next = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q     <= '0;
      gf_q     <= CAP_P;
      sel_on_q <= 1'b0;
      anchor_q <= '0;
      tail_q   <= '0;
      idx_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      tgt_q    <= '0;
      n_q      <= '0;
      status_q <= 1'b0;
      hit_q    <= 1'b0;
      char_q   <= '0;
    end else begin
      case (cmd_i)
        gbte_pkg::CMD_LATCH: begin
          status_q <= 1'b0;
          char_q   <= '0;
        end
        gbte_pkg::CMD_INSERT: begin
          if (full) begin
            status_q <= 1'b1;
          end else begin
            gb_q <= gb_q + PW'(1);
          end
        end
        gbte_pkg::CMD_BACKSPACE: begin
          if (gb_q != '0 && !sel_on_q) begin
            gb_q <= gb_q - PW'(1);
          end
        end
        gbte_pkg::CMD_SEL_PRE: begin
          if (ext_q) begin
            if (!sel_on_q) begin
              sel_on_q <= 1'b1;
              anchor_q <= gb_q;
              tail_q   <= gb_q;
            end
          end else begin
            sel_on_q <= 1'b0;
            anchor_q <= '0;
            tail_q   <= '0;
          end
        end
        gbte_pkg::CMD_SEL_POST: begin
          if (ext_q) begin
            tail_q <= gb_q;
          end
        end
        gbte_pkg::CMD_DROP_SEL: begin
          sel_on_q <= 1'b0;
          anchor_q <= '0;
          tail_q   <= '0;
        end
        gbte_pkg::CMD_MV_LEFT: begin
          gb_q <= gb_q - PW'(1);
          gf_q <= gf_q - PW'(1);
        end
        gbte_pkg::CMD_MV_RIGHT: begin
          gb_q <= gb_q + PW'(1);
          gf_q <= gf_q + PW'(1);
        end
        gbte_pkg::CMD_MV_RIGHT_CNT: begin
          gb_q <= gb_q + PW'(1);
          gf_q <= gf_q + PW'(1);
          n_q  <= n_q + CW'(1);
        end
        gbte_pkg::CMD_LOC_CLR: begin
          idx_q <= '0;
          row_q <= '0;
          col_q <= '0;
        end
        gbte_pkg::CMD_LOC_ACC: begin
          idx_q <= idx_q + PW'(1);
          col_q <= col_next;
          if (rd_q == gbte_pkg::CH_LF) begin
            row_q <= row_q + PW'(1);
          end
        end
        gbte_pkg::CMD_TGT_SAVE: begin
          tgt_q <= col_q;
          n_q   <= '0;
        end
        gbte_pkg::CMD_READ_ISSUE: hit_q <= hit;
        gbte_pkg::CMD_READ_CAPT:  char_q <= hit_q ? rd_q : 8'd0;
        default: ;
      endcase
    end
  end

  logic [31:0] gb_w, row_w, len_w, anchor_w, tail_w;
  logic [15:0] col_sat;
  assign gb_w     = 32'(gb_q);
  assign row_w    = 32'(row_q);
  assign len_w    = 32'(len);
  assign anchor_w = 32'(anchor_q);
  assign tail_w   = 32'(tail_q);
  assign col_sat  = (|col_q[CW-1:16]) ? 16'hFFFF : col_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == gbte_pkg::CMD_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == gbte_pkg::CMD_OUT_LOAD) begin
      status_o       <= status_q;
      cursor_index_o <= gb_w[12:0];
      cursor_row_o   <= row_w[12:0];
      cursor_col_o   <= col_sat;
      text_length_o  <= len_w[12:0];
      sel_active_o   <= sel_on_q;
      sel_anchor_o   <= anchor_w[12:0];
      sel_end_o      <= tail_w[12:0];
      char_out_o     <= char_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sts_o = '{
    kind:      gbte_pkg::kind_e'(kind_q),
    bs_char:   (ch_q == gbte_pkg::CH_BS) || (ch_q == gbte_pkg::CH_DEL),
    gb_zero:   (gb_q == '0),
    at_end:    (gf_q >= CAP_P),
    rd_lf:     (rd_q == gbte_pkg::CH_LF),
    loc_done:  (idx_q == gb_q),
    walk_done: (n_q >= tgt_q),
    out_busy:  out_valid_q && !out_ready_i
  };

endmodule
`default_nettype wire

### sv/gbte_ctrl.sv
// gap buffer editor: command sequencer
`default_nettype none
module gbte_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire gbte_pkg::dp_sts_t sts_i,
  output gbte_pkg::cmd_e    cmd_o
);

  gbte_pkg::state_e state_q, state_d;
  logic tgt_phase_q, tgt_phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbte_pkg::S_IDLE;
      tgt_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_phase_q <= tgt_phase_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    tgt_phase_d = tgt_phase_q;
    case (state_q)
      gbte_pkg::S_IDLE: if (in_valid_i) state_d = gbte_pkg::S_DECODE;
      gbte_pkg::S_DECODE: begin
        tgt_phase_d = 1'b0;
        case (sts_i.kind)
          gbte_pkg::K_READ:  state_d = gbte_pkg::S_READ_WAIT;
          gbte_pkg::K_LEFT:  state_d = gbte_pkg::S_LEFT;
          gbte_pkg::K_RIGHT: state_d = gbte_pkg::S_RIGHT;
          gbte_pkg::K_UP, gbte_pkg::K_DOWN: begin
            state_d     = gbte_pkg::S_LOC_START;
            tgt_phase_d = 1'b1;
          end
          default: state_d = gbte_pkg::S_LOC_START;
        endcase
      end
      gbte_pkg::S_READ_WAIT: state_d = gbte_pkg::S_LOC_START;
      gbte_pkg::S_LEFT:
        state_d = sts_i.gb_zero ? gbte_pkg::S_SEL_POST : gbte_pkg::S_LEFT_WR;
      gbte_pkg::S_LEFT_WR: state_d = gbte_pkg::S_SEL_POST;
      gbte_pkg::S_RIGHT:
        state_d = sts_i.at_end ? gbte_pkg::S_SEL_POST : gbte_pkg::S_RIGHT_WR;
      gbte_pkg::S_RIGHT_WR: state_d = gbte_pkg::S_SEL_POST;
      gbte_pkg::S_UP:
        state_d = sts_i.gb_zero ? gbte_pkg::S_SEL_POST : gbte_pkg::S_UP_CHK;
      gbte_pkg::S_UP_CHK:
        state_d = sts_i.rd_lf ? gbte_pkg::S_UP_LINE : gbte_pkg::S_UP;
      gbte_pkg::S_UP_LINE:
        state_d = sts_i.gb_zero ? gbte_pkg::S_WALK : gbte_pkg::S_UP_LINE_CHK;
      gbte_pkg::S_UP_LINE_CHK:
        state_d = sts_i.rd_lf ? gbte_pkg::S_WALK : gbte_pkg::S_UP_LINE;
      gbte_pkg::S_DOWN:
        state_d = sts_i.at_end ? gbte_pkg::S_SEL_POST : gbte_pkg::S_DOWN_CHK;
      gbte_pkg::S_DOWN_CHK:
        state_d = sts_i.rd_lf ? gbte_pkg::S_WALK : gbte_pkg::S_DOWN;
      gbte_pkg::S_WALK:
        state_d = (sts_i.walk_done || sts_i.at_end) ? gbte_pkg::S_SEL_POST
                                                    : gbte_pkg::S_WALK_CHK;
      gbte_pkg::S_WALK_CHK:
        state_d = sts_i.rd_lf ? gbte_pkg::S_SEL_POST : gbte_pkg::S_WALK;
      gbte_pkg::S_SEL_POST: begin
        state_d     = gbte_pkg::S_LOC_START;
        tgt_phase_d = 1'b0;
      end
      gbte_pkg::S_LOC_START: state_d = gbte_pkg::S_LOC_CHK;
      gbte_pkg::S_LOC_CHK: begin
        if (!sts_i.loc_done) begin
          state_d = gbte_pkg::S_LOC_ACC;
        end else if (tgt_phase_q) begin
          state_d = gbte_pkg::S_TGT;
        end else begin
          state_d = gbte_pkg::S_FINISH;
        end
      end
      gbte_pkg::S_LOC_ACC: state_d = gbte_pkg::S_LOC_CHK;
      gbte_pkg::S_TGT:
        state_d = (sts_i.kind == gbte_pkg::K_UP) ? gbte_pkg::S_UP : gbte_pkg::S_DOWN;
      gbte_pkg::S_FINISH: if (!sts_i.out_busy) state_d = gbte_pkg::S_IDLE;
      default: state_d = gbte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = gbte_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      gbte_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = gbte_pkg::CMD_LATCH;
      end
      gbte_pkg::S_DECODE: begin
        case (sts_i.kind)
          gbte_pkg::K_INSERT:
            cmd_o = sts_i.bs_char ? gbte_pkg::CMD_BACKSPACE : gbte_pkg::CMD_INSERT;
          gbte_pkg::K_BACKSPACE: cmd_o = gbte_pkg::CMD_BACKSPACE;
          gbte_pkg::K_CLEAR:     cmd_o = gbte_pkg::CMD_DROP_SEL;
          gbte_pkg::K_READ:      cmd_o = gbte_pkg::CMD_READ_ISSUE;
          default:               cmd_o = gbte_pkg::CMD_SEL_PRE;
        endcase
      end
      gbte_pkg::S_READ_WAIT: cmd_o = gbte_pkg::CMD_READ_CAPT;
      gbte_pkg::S_LEFT, gbte_pkg::S_UP, gbte_pkg::S_UP_LINE:
        if (!sts_i.gb_zero) cmd_o = gbte_pkg::CMD_RD_PREV;
      gbte_pkg::S_LEFT_WR, gbte_pkg::S_UP_CHK: cmd_o = gbte_pkg::CMD_MV_LEFT;
      gbte_pkg::S_UP_LINE_CHK: if (!sts_i.rd_lf) cmd_o = gbte_pkg::CMD_MV_LEFT;
      gbte_pkg::S_RIGHT, gbte_pkg::S_DOWN:
        if (!sts_i.at_end) cmd_o = gbte_pkg::CMD_RD_FIN;
      gbte_pkg::S_RIGHT_WR, gbte_pkg::S_DOWN_CHK: cmd_o = gbte_pkg::CMD_MV_RIGHT;
      gbte_pkg::S_WALK:
        if (!sts_i.walk_done && !sts_i.at_end) cmd_o = gbte_pkg::CMD_RD_FIN;
      gbte_pkg::S_WALK_CHK: if (!sts_i.rd_lf) cmd_o = gbte_pkg::CMD_MV_RIGHT_CNT;
      gbte_pkg::S_SEL_POST:  cmd_o = gbte_pkg::CMD_SEL_POST;
      gbte_pkg::S_LOC_START: cmd_o = gbte_pkg::CMD_LOC_CLR;
      gbte_pkg::S_LOC_CHK:   if (!sts_i.loc_done) cmd_o = gbte_pkg::CMD_LOC_RD;
      gbte_pkg::S_LOC_ACC:   cmd_o = gbte_pkg::CMD_LOC_ACC;
      gbte_pkg::S_TGT:       cmd_o = gbte_pkg::CMD_TGT_SAVE;
      gbte_pkg::S_FINISH:    if (!sts_i.out_busy) cmd_o = gbte_pkg::CMD_OUT_LOAD;
      default:               cmd_o = gbte_pkg::CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

### sv/gap_buffer_text_editor_top.sv
// gap buffer editor: top level
// Gap-buffer text store of CAPACITY bytes driven by one edit command per word.
// Input channel (in_valid_i/in_ready_o) carries kind, extend, char_code and
// position; output channel (out_valid_o/out_ready_i) returns one result word
// per command with cursor index, row, column, text length, selection and
// the byte read.
// One command is processed at a time. Every command ends with a scan of the
// text before the cursor to work out row and column: each byte before the
// cursor is read and then accumulated, through the single read port of the
// text memory. Up and down also run an earlier scan for the target column
// and then move the cursor across the gap one byte at a time, each byte
// read and then written back on the other side of the gap.
// Reset empties the text, puts the cursor at 0 and drops the selection;
// no clearing pass over the memory is needed.
// The result sits in an output register; a new word is accepted while it
// waits, but the next result is held back until the receiver takes it.
`default_nettype none
module gap_buffer_text_editor_top #(
  parameter int unsigned CAPACITY = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic        extend_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [11:0] position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [12:0]      cursor_index_o,
  output logic [12:0]      cursor_row_o,
  output logic [15:0]      cursor_col_o,
  output logic [12:0]      text_length_o,
  output logic             sel_active_o,
  output logic [12:0]      sel_anchor_o,
  output logic [12:0]      sel_end_o,
  output logic [7:0]       char_out_o
);

  gbte_pkg::cmd_e    cmd;
  gbte_pkg::dp_sts_t sts;

  gbte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbte_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .extend_i       (extend_i),
    .char_code_i    (char_code_i),
    .position_i     (position_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .cursor_index_o (cursor_index_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_col_o   (cursor_col_o),
    .text_length_o  (text_length_o),
    .sel_active_o   (sel_active_o),
    .sel_anchor_o   (sel_anchor_o),
    .sel_end_o      (sel_end_o),
    .char_out_o     (char_out_o),
    .sts_o          (sts)
  );

endmodule
`default_nettype wire

### sv/gbte_checker.sv
// gap buffer editor: port-level assertions and bind
`default_nettype none
module gbte_checker #(
  parameter int unsigned CAPACITY = 4096
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  kind_i,
  input wire logic        extend_i,
  input wire logic [7:0]  char_code_i,
  input wire logic [11:0] position_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        status_o,
  input wire logic [12:0] cursor_index_o,
  input wire logic [12:0] cursor_row_o,
  input wire logic [15:0] cursor_col_o,
  input wire logic [12:0] text_length_o,
  input wire logic        sel_active_o,
  input wire logic [12:0] sel_anchor_o,
  input wire logic [12:0] sel_end_o,
  input wire logic [7:0]  char_out_o
);

  localparam logic [31:0] CAP_W = 32'(CAPACITY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_sel_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sel_active_o |-> sel_anchor_o == '0 && sel_end_o == '0)
    else $error("inactive selection with nonzero ends");

  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> text_length_o == CAP_W[12:0])
    else $error("insert refused while store not full");

  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CAPACITY < 8192 |-> cursor_index_o <= text_length_o)
    else $error("cursor beyond text length");

endmodule

bind gap_buffer_text_editor_top gbte_checker #(.CAPACITY(CAPACITY)) u_gbte_checker (.*);
`default_nettype wire

### bench/gap_buffer_text_editor_top_test.sv
// gap buffer editor: self-checking testbench with its own edit predictor
`timescale 1ns / 1ps
module gap_buffer_text_editor_top_test;

  localparam int CAP = 4096;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    gbte_pkg::kind_e kind;
    logic       extend;
    logic [7:0] ch;
    logic [11:0] pos;
  } edit_t;

  typedef struct {
    logic        status;
    logic [12:0] index;
    logic [12:0] row;
    logic [15:0] col;
    logic [12:0] length;
    logic        sel_on;
    logic [12:0] sel_a;
    logic [12:0] sel_b;
    logic [7:0]  ch_out;
  } view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i = '0;
  logic        extend_i = 1'b0;
  logic [7:0]  char_code_i = '0;
  logic [11:0] position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o;
  logic [12:0] cursor_index_o, cursor_row_o, text_length_o, sel_anchor_o, sel_end_o;
  logic [15:0] cursor_col_o;
  logic        sel_active_o;
  logic [7:0]  char_out_o;

  gap_buffer_text_editor_top u_top (.*);

  edit_t pending_edits[$];
  view_t expected_views[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    n_errors = 0;
  int    n_words_in = 0;
  int    n_words_out = 0;
  int    quiet_cycles = 0;

  // logical text and cursor kept by the predictor
  logic [7:0] text_buf [CAP];
  int         text_len = 0;
  int         cursor = 0;
  logic       sel_on = 1'b0;
  int         sel_anchor = 0;
  int         sel_tail = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void find_row_col(output int row, output int col);
    row = 0;
    col = 0;
    for (int i = 0; i < cursor; i++) begin
      if (text_buf[i] == gbte_pkg::CH_LF) begin
        row++;
        col = 0;
      end else if (text_buf[i] == gbte_pkg::CH_TAB) begin
        col = (col / 8 + 1) * 8;
      end else begin
        col++;
      end
    end
  endfunction

  function automatic void walk_cols(int target);
    int n;
    n = 0;
    while (n < target && cursor < text_len && text_buf[cursor] != gbte_pkg::CH_LF) begin
      cursor++;
      n++;
    end
  endfunction

  function automatic void rub_out();
    if (cursor > 0 && !sel_on) begin
      for (int i = cursor - 1; i < text_len - 1; i++) text_buf[i] = text_buf[i + 1];
      cursor--;
      text_len--;
    end
  endfunction

  function automatic view_t apply_edit(edit_t e);
    view_t v;
    int row, col;
    v.status = 1'b0;
    v.ch_out = '0;
    case (e.kind)
      gbte_pkg::K_INSERT: begin
        if (e.ch == gbte_pkg::CH_BS || e.ch == gbte_pkg::CH_DEL) begin
          rub_out();
        end else if (text_len >= CAP) begin
          v.status = 1'b1;
        end else begin
          for (int i = text_len; i > cursor; i--) text_buf[i] = text_buf[i - 1];
          text_buf[cursor] = (e.ch == gbte_pkg::CH_CR) ? gbte_pkg::CH_LF : e.ch;
          cursor++;
          text_len++;
        end
      end
      gbte_pkg::K_BACKSPACE: rub_out();
      gbte_pkg::K_LEFT, gbte_pkg::K_RIGHT, gbte_pkg::K_UP, gbte_pkg::K_DOWN: begin
        find_row_col(row, col);
        if (e.extend) begin
          if (!sel_on) begin
            sel_on = 1'b1;
            sel_anchor = cursor;
            sel_tail = cursor;
          end
        end else begin
          sel_on = 1'b0;
          sel_anchor = 0;
          sel_tail = 0;
        end
        case (e.kind)
          gbte_pkg::K_LEFT: if (cursor > 0) cursor--;
          gbte_pkg::K_RIGHT: if (cursor < text_len) cursor++;
          gbte_pkg::K_UP: begin
            if (cursor > 0) begin
              while (cursor > 0 && text_buf[cursor - 1] != gbte_pkg::CH_LF) cursor--;
              if (cursor > 0) begin
                cursor--;
                while (cursor > 0 && text_buf[cursor - 1] != gbte_pkg::CH_LF) cursor--;
                walk_cols(col);
              end
            end
          end
          default: begin
            while (cursor < text_len && text_buf[cursor] != gbte_pkg::CH_LF) cursor++;
            if (cursor < text_len) begin
              cursor++;
              walk_cols(col);
            end
          end
        endcase
        if (e.extend) sel_tail = cursor;
      end
      gbte_pkg::K_CLEAR: begin
        sel_on = 1'b0;
        sel_anchor = 0;
        sel_tail = 0;
      end
      default: if (int'(e.pos) < text_len) v.ch_out = text_buf[e.pos];
    endcase
    find_row_col(row, col);
    v.index = 13'(cursor);
    v.row = 13'(row);
    v.col = (col > 65535) ? 16'hffff : 16'(col);
    v.length = 13'(text_len);
    v.sel_on = sel_on;
    v.sel_a = 13'(sel_anchor);
    v.sel_b = 13'(sel_tail);
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on word %0d: %s got %0d expected %0d", n_words_out, what, got, want);
    n_errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_views.insert(expected_views.size(),
                            apply_edit('{gbte_pkg::kind_e'(kind_i), extend_i, char_code_i,
                                         position_i}));
      n_words_in++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && pending_edits.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        edit_t e;
        e = pending_edits.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= e.kind;
        extend_i <= e.extend;
        char_code_i <= e.ch;
        position_i <= e.pos;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (out_valid_o && out_ready_i) begin
      view_t w;
      n_words_out++;
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = expected_views.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (cursor_index_o !== w.index) report_mismatch("cursor_index", cursor_index_o, w.index);
        if (cursor_row_o !== w.row) report_mismatch("cursor_row", cursor_row_o, w.row);
        if (cursor_col_o !== w.col) report_mismatch("cursor_col", cursor_col_o, w.col);
        if (text_length_o !== w.length) report_mismatch("text_length", text_length_o, w.length);
        if (sel_active_o !== w.sel_on) report_mismatch("sel_active", sel_active_o, w.sel_on);
        if (sel_anchor_o !== w.sel_a) report_mismatch("sel_anchor", sel_anchor_o, w.sel_a);
        if (sel_end_o !== w.sel_b) report_mismatch("sel_end", sel_end_o, w.sel_b);
        if (char_out_o !== w.ch_out) report_mismatch("char_out", char_out_o, w.ch_out);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_edit(gbte_pkg::kind_e k, logic x, logic [7:0] c,
                                   logic [11:0] p);
    edit_t e;
    e = '{k, x, c, p};
    pending_edits.insert(pending_edits.size(), e);
  endfunction

  function automatic void add_random_edit();
    int pick;
    logic [7:0] c;
    logic [11:0] p;
    pick = $urandom_range(99);
    case ($urandom_range(4))
      0: c = gbte_pkg::CH_LF;
      1: c = gbte_pkg::CH_TAB;
      2: c = gbte_pkg::CH_CR;
      default: c = 8'($urandom_range(255));
    endcase
    p = ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(40));
    if (pick < 40) add_edit(gbte_pkg::K_INSERT, 1'($urandom_range(1)), c, p);
    else add_edit(gbte_pkg::kind_e'($urandom_range(7)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), p);
  endfunction

  task automatic drain();
    while (pending_edits.size() != 0 || in_valid_i || expected_views.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_edit(gbte_pkg::K_BACKSPACE, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_LEFT, 1'b1, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_UP, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, gbte_pkg::CH_TAB, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, 8'd255, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, gbte_pkg::CH_CR, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, 8'h41, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, gbte_pkg::CH_TAB, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, gbte_pkg::CH_DEL, 12'd0);
    add_edit(gbte_pkg::K_INSERT, 1'b0, gbte_pkg::CH_BS, 12'd0);
    add_edit(gbte_pkg::K_RIGHT, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_UP, 1'b1, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_BACKSPACE, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_DOWN, 1'b1, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_DOWN, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_LEFT, 1'b1, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_CLEAR, 1'b1, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_READ, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_READ, 1'b0, 8'd0, 12'd1);
    add_edit(gbte_pkg::K_READ, 1'b0, 8'd0, 12'd4);
    add_edit(gbte_pkg::K_READ, 1'b0, 8'd0, 12'd4095);
    add_edit(gbte_pkg::K_UP, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_UP, 1'b0, 8'd0, 12'd0);
    add_edit(gbte_pkg::K_BACKSPACE, 1'b0, 8'd0, 12'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 22) : 0;
      recv_stall_pct = (ph == 2) ? 59 : ((ph == 3) ? 22 : 0);
      for (int i = 0; i < 19; i++) add_random_edit();
      drain();
    end
    repeat (100) @(posedge clk_i);

    $display("covered %0d edit words and %0d result words over four idling mixes,",
             n_words_in, n_words_out);
    $display("ending with %0d characters held", text_len);
    if (n_errors == 0 && expected_views.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
sv/gbte_pkg.sv
sv/gbte_dpath.sv
sv/gbte_ctrl.sv
sv/gap_buffer_text_editor_top.sv
sv/gbte_checker.sv
bench/gap_buffer_text_editor_top_test.sv
